// File: hdl/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_writer_assert
// Assertion macros shared by the console writer.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// condition must hold in the same cycle
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer: transfer payloads, action
// codes, character codes and the cell layout.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_BACK  = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [7:0] NEWLINE_CODE   = 8'd10;
  localparam logic [7:0] BLANK_CODE     = 8'd32;
  localparam logic [7:0] DEFAULT_COLOUR = 8'h0F;

  localparam int CELL_W = 16;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_colour;
  } out_item_t;

  // attribute in the high byte, character in the low byte
  typedef struct packed {
    logic [7:0] colour;
    logic [7:0] code;
  } cell_t;

endpackage

// File: hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/tcw_addr_unit.sv
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared cell address unit: row times the line length plus column, registered.
// ----------------------------------------------------------------------------
module tcw_addr_unit #(
  parameter int COLUMNS = 80,
  parameter int ROW_W   = 5,
  parameter int COL_W   = 7,
  parameter int ADDR_W  = 11
) (
  input  logic              clk,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  output logic [ADDR_W-1:0] addr
);

  always_ff @(posedge clk) begin
    addr <= ADDR_W'(int'(row) * COLUMNS + int'(col));
  end

endmodule

// File: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: a ROWS by COLUMNS cell store with a cursor,
// handling put character, clear screen, step back and read cell.
//
//   channel   signals                      payload
//   input     in_valid / in_ready          in_data  (tcw_pkg::in_item_t)
//   output    out_valid / out_ready        out_data (tcw_pkg::out_item_t)
//   config    cfg_write                    cfg_data (text colour)
//
// put character computes the cell address, then writes the cell (a newline
// writes no cell); step back and a read off the screen go straight to the
// result; read cell computes the address, reads and takes the data. clear
// screen and a scroll go cell by cell, set by the single write port of the
// cell store. after reset a clearing pass fills every cell of the store; no
// item is taken meanwhile. one item is in work at a time; a finished result
// holds the block until the output transfer frees the output register.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_data
);

  localparam int CELLS        = ROWS * COLUMNS;
  localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W       = $clog2(CELLS);
  localparam int ROW_W        = $clog2(ROWS);
  localparam int COL_W        = $clog2(COLUMNS + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WADDR, S_WRITE, S_SCROLL, S_BLANK,
    S_CLEAR, S_RADDR, S_RREAD, S_RDATA, S_DONE
  } state_t;

  state_t state;

  logic [7:0]        text_colour;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] src;
  logic              pend;
  logic              put_pend;
  logic [7:0]        req_code;
  logic [ROW_W-1:0]  req_row;
  logic [COL_W-1:0]  req_col;
  logic [7:0]        cell_char;
  logic [7:0]        cell_colour;

  logic [ROW_W-1:0]  au_row;
  logic [COL_W-1:0]  au_col;
  logic [ADDR_W-1:0] au_addr;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_wa;
  tcw_pkg::cell_t             ram_wd;
  logic                       ram_re;
  logic [ADDR_W-1:0]          ram_ra;
  logic [tcw_pkg::CELL_W-1:0] ram_rd;
  tcw_pkg::cell_t             rd_cell;

  logic in_fire;
  logic wrap;
  logic in_range;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign rd_cell  = tcw_pkg::cell_t'(ram_rd);
  assign wrap     = (in_data.char_code == tcw_pkg::NEWLINE_CODE) ||
                    (cur_col >= COL_W'(COLUMNS));
  assign in_range = (int'(in_data.read_row) < ROWS) && (int'(in_data.read_col) < COLUMNS);

  // address unit serves the cursor on writes and the request on reads
  always_comb begin
    if (state == S_RADDR) begin
      au_row = req_row;
      au_col = req_col;
    end else begin
      au_row = cur_row;
      au_col = cur_col;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = cnt;
    ram_wd = '{colour: text_colour, code: tcw_pkg::BLANK_CODE};
    ram_re = 1'b0;
    ram_ra = src;
    unique case (state)
      S_INIT: begin
        ram_we = 1'b1;
        ram_wd = '{colour: tcw_pkg::DEFAULT_COLOUR, code: tcw_pkg::BLANK_CODE};
      end
      S_CLEAR, S_BLANK: begin
        ram_we = 1'b1;
      end
      S_SCROLL: begin
        ram_re = 1'b1;
        ram_we = pend;
        ram_wd = rd_cell;
      end
      S_WRITE: begin
        ram_we = 1'b1;
        ram_wa = au_addr;
        ram_wd = '{colour: text_colour, code: req_code};
      end
      S_RREAD: begin
        ram_re = 1'b1;
        ram_ra = au_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      cnt         <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      pend        <= 1'b0;
      put_pend    <= 1'b0;
      out_valid   <= 1'b0;
      text_colour <= tcw_pkg::DEFAULT_COLOUR;
    end else begin
      if (cfg_write) begin
        text_colour <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (cnt == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            req_code    <= in_data.char_code;
            req_row     <= ROW_W'(in_data.read_row);
            req_col     <= COL_W'(in_data.read_col);
            cell_char   <= '0;
            cell_colour <= '0;
            put_pend    <= (in_data.char_code != tcw_pkg::NEWLINE_CODE);
            unique case (in_data.action)
              tcw_pkg::ACT_PUT: begin
                if (wrap) begin
                  cur_col <= '0;
                  if (cur_row < ROW_W'(ROWS - 1)) begin
                    cur_row <= cur_row + 1'b1;
                    state   <= (in_data.char_code == tcw_pkg::NEWLINE_CODE) ? S_DONE
                                                                            : S_WADDR;
                  end else begin
                    cnt   <= '0;
                    src   <= ADDR_W'(COLUMNS);
                    pend  <= 1'b0;
                    state <= S_SCROLL;
                  end
                end else begin
                  state <= S_WADDR;
                end
              end
              tcw_pkg::ACT_CLEAR: begin
                cnt   <= '0;
                state <= S_CLEAR;
              end
              tcw_pkg::ACT_BACK: begin
                if (cur_col != '0) begin
                  cur_col <= cur_col - 1'b1;
                end
                state <= S_DONE;
              end
              tcw_pkg::ACT_READ: begin
                state <= in_range ? S_RADDR : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_WADDR: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          cur_col <= cur_col + 1'b1;
          state   <= S_DONE;
        end
        S_SCROLL: begin
          // read runs one cell ahead of the write, a line further on
          pend <= 1'b1;
          if (src != ADDR_W'(CELLS - 1)) begin
            src <= src + 1'b1;
          end
          if (pend) begin
            if (cnt == ADDR_W'(SCROLL_CELLS - 1)) begin
              cnt   <= ADDR_W'(SCROLL_CELLS);
              state <= S_BLANK;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_BLANK: begin
          if (cnt == ADDR_W'(CELLS - 1)) begin
            state <= put_pend ? S_WADDR : S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CLEAR: begin
          if (cnt == ADDR_W'(CELLS - 1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_RADDR: begin
          state <= S_RREAD;
        end
        S_RREAD: begin
          state <= S_RDATA;
        end
        S_RDATA: begin
          cell_char   <= rd_cell.code;
          cell_colour <= rd_cell.colour;
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.cursor_row  <= 5'(cur_row);
            out_data.cursor_col  <= 7'(cur_col);
            out_data.cell_char   <= cell_char;
            out_data.cell_colour <= cell_colour;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tcw_addr_unit #(
    .COLUMNS (COLUMNS),
    .ROW_W   (ROW_W),
    .COL_W   (COL_W),
    .ADDR_W  (ADDR_W)
  ) u_addr (
    .clk  (clk),
    .row  (au_row),
    .col  (au_col),
    .addr (au_addr)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

`include "text_console_writer_assert.svh"

  `TCW_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_fire, !in_ready,
                   "block still ready after an input transfer")
  `TCW_ASSERT_NOW(a_cursor_bounds, clk, rst, 1'b1,
                  (int'(cur_row) < ROWS) && (int'(cur_col) <= COLUMNS),
                  "cursor outside the screen")
  `TCW_ASSERT_NOW(a_scroll_order, clk, rst, (state == S_SCROLL) && pend, src > cnt,
                  "scroll write overtook its read")

endmodule
